@@ sv/pjrt_pkg.sv @@
// ----------------------------------------------------------------------------
// pjrt_pkg
// Shared types and constants for the peer join and replay table.
// ----------------------------------------------------------------------------
package pjrt_pkg;

  localparam int unsigned TableEntriesDef = 16;

  localparam logic [1:0] OpJoinReq = 2'd0;
  localparam logic [1:0] OpJoinCfm = 2'd1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StUnknown  = 3'd1;
  localparam logic [2:0] StFull     = 3'd2;
  localparam logic [2:0] StChecksum = 3'd3;
  localparam logic [2:0] StReplay   = 3'd4;
  localparam logic [2:0] StNonce    = 3'd5;

  localparam logic [15:0] LockedCount = 16'hFFFF;
  localparam logic [15:0] ZeroCount   = 16'h0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] peer_addr_high;
    logic [63:0] peer_addr_low;
    logic [15:0] fresh_nonce;
    logic [15:0] echoed_nonce;
    logic [15:0] packet_count;
    logic        checksum_good;
  } pjrt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] session_nonce;
  } pjrt_out_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic eval;
  } pjrt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } pjrt_sts_t;

endpackage

@@ sv/pjrt_datapath.sv @@
// ----------------------------------------------------------------------------
// pjrt_datapath
// Entry memory, sequential address scan, decision logic and result register.
// ----------------------------------------------------------------------------
module pjrt_datapath
  import pjrt_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pjrt_in_t  in_data_i,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output pjrt_out_t out_data_o,
  input  pjrt_cmd_t cmd_i,
  output pjrt_sts_t sts_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned PtrW = $clog2(TableEntries + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);
  localparam logic [PtrW-1:0] PtrEnd  = PtrW'(TableEntries);

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] cnt;
    logic [15:0] nonce;
  } entry_t;

  entry_t                  mem_q [TableEntries];
  logic [TableEntries-1:0] vld_q;

  pjrt_in_t        item_q;
  logic [PtrW-1:0] ptr_q;
  logic            chk_q;
  logic [IdxW-1:0] chk_idx_q;
  entry_t          rd_q;
  logic            rd_vld_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [15:0]     hit_cnt_q;
  logic [15:0]     hit_nonce_q;
  logic            emp_q;
  logic [IdxW-1:0] emp_idx_q;
  pjrt_out_t       out_q;
  logic            out_valid_q;

  logic            issue;
  logic            cmp_en;
  entry_t          cur;
  logic            match;
  logic            empty;
  logic            hit_upd;
  logic            emp_upd;
  logic            we;
  logic            wr_en;
  logic [IdxW-1:0] w_idx;
  entry_t          w_entry;
  pjrt_out_t       res;
  logic [16:0]     want;

  assign issue   = cmd_i.scan && (ptr_q != PtrEnd);
  assign cmp_en  = cmd_i.scan && chk_q;
  assign cur     = rd_vld_q ? rd_q : '1;
  assign match   = (cur.addr_hi == item_q.peer_addr_high) &&
                   (cur.addr_lo == item_q.peer_addr_low);
  assign empty   = (&cur.addr_hi) && (&cur.addr_lo);
  assign hit_upd = cmp_en && match && !hit_q;
  assign emp_upd = cmp_en && empty && !emp_q;
  assign want    = {1'b0, hit_nonce_q} + 17'd1;

  always_comb begin
    res               = '0;
    res.status        = StUnknown;
    we                = 1'b0;
    w_idx             = hit_idx_q;
    w_entry.addr_hi   = item_q.peer_addr_high;
    w_entry.addr_lo   = item_q.peer_addr_low;
    w_entry.cnt       = hit_cnt_q;
    w_entry.nonce     = hit_nonce_q;
    priority if (item_q.op == OpJoinReq) begin
      w_entry.cnt   = LockedCount;
      w_entry.nonce = item_q.fresh_nonce;
      if (hit_q || emp_q) begin
        we                = 1'b1;
        w_idx             = hit_q ? hit_idx_q : emp_idx_q;
        res.status        = StOk;
        res.slot          = 4'(w_idx);
        res.session_nonce = item_q.fresh_nonce;
      end else begin
        res.status = StFull;
      end
    end else if (!hit_q) begin
      res.status = StUnknown;
    end else begin
      res.slot          = 4'(hit_idx_q);
      res.session_nonce = hit_nonce_q;
      priority if (item_q.op == OpJoinCfm) begin
        if (want != {1'b0, item_q.echoed_nonce}) begin
          res.status = StNonce;
        end else begin
          we          = 1'b1;
          w_entry.cnt = ZeroCount;
          res.status  = StOk;
        end
      end else if (!item_q.checksum_good) begin
        res.status = StChecksum;
      end else if (hit_cnt_q >= item_q.packet_count) begin
        res.status = StReplay;
      end else begin
        we          = 1'b1;
        w_entry.cnt = item_q.packet_count;
        res.status  = StOk;
      end
    end
  end

  assign wr_en = we && cmd_i.eval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      chk_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      emp_q       <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chk_q <= issue;
      if (cmd_i.start) begin
        ptr_q <= '0;
        hit_q <= 1'b0;
        emp_q <= 1'b0;
      end else begin
        if (issue) ptr_q <= ptr_q + PtrW'(1);
        if (hit_upd) hit_q <= 1'b1;
        if (emp_upd) emp_q <= 1'b1;
      end
      if (issue) rd_vld_q <= vld_q[ptr_q[IdxW-1:0]];
      if (wr_en) vld_q[w_idx] <= 1'b1;
      if (cmd_i.eval) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) item_q <= in_data_i;
    if (issue) chk_idx_q <= ptr_q[IdxW-1:0];
    if (hit_upd) begin
      hit_idx_q   <= chk_idx_q;
      hit_cnt_q   <= cur.cnt;
      hit_nonce_q <= cur.nonce;
    end
    if (emp_upd) emp_idx_q <= chk_idx_q;
    if (cmd_i.eval) out_q <= res;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[w_idx] <= w_entry;
    if (issue) rd_q <= mem_q[ptr_q[IdxW-1:0]];
  end

  assign sts_o.scan_done = cmp_en && (match || (chk_idx_q == LastIdx));
  assign sts_o.out_busy  = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q && !cmd_i.start) |=> hit_q)
    else $error("hit flag lost during an item");

  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (hit_q || emp_q))
    else $error("table write without a located slot");

endmodule

@@ sv/pjrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// pjrt_ctrl
// Sequencer: accept, scan the table, decide and commit one item at a time.
// ----------------------------------------------------------------------------
module pjrt_ctrl
  import pjrt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output pjrt_cmd_t cmd_o,
  input  pjrt_sts_t sts_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEval
  } state_e;

  state_e state_q;
  logic   stall_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stall_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StScan;
            stall_q <= 1'b1;
          end
        end
        StScan: begin
          if (sts_i.scan_done) state_q <= StEval;
        end
        StEval: begin
          if (!sts_i.out_busy) begin
            state_q <= StIdle;
            stall_q <= 1'b0;
          end
        end
        default: begin
          state_q <= StIdle;
          stall_q <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o.start = (state_q == StIdle) && in_valid_i;
  assign cmd_o.scan  = (state_q == StScan);
  assign cmd_o.eval  = (state_q == StEval) && !sts_i.out_busy;
  assign in_stall_o  = stall_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> stall_q)
    else $error("input open while an item is in flight");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.scan_done |-> (state_q == StScan))
    else $error("scan completion outside scan");

  a_start_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == StScan))
    else $error("accepted item did not start a scan");

endmodule

@@ sv/peer_join_and_replay_table.sv @@
// ----------------------------------------------------------------------------
// peer_join_and_replay_table
// Per-peer join and replay table keyed by a 128-bit peer address.
//
//   channel | dir | valid       | stall        | payload
//   --------+-----+-------------+--------------+-----------------------
//   input   | in  | in_valid_i  | in_stall_o   | in_data_i  (pjrt_in_t)
//   result  | out | out_valid_o | out_stall_i  | out_data_o (pjrt_out_t)
//
// The scan of the table memory reads one entry per cycle and stops at the slot
// that holds the peer, or at the last entry when the peer is not found. One
// result per item.
// Reset clears the per-entry valid bits at once; an unwritten entry reads as
// all ones, so no clearing pass is needed.
// A stalled result sits in the output register while the next item scans.
// ----------------------------------------------------------------------------
module peer_join_and_replay_table
  import pjrt_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pjrt_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pjrt_out_t out_data_o
);

  pjrt_cmd_t cmd;
  pjrt_sts_t sts;

  pjrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  pjrt_datapath #(
    .TableEntries (TableEntries)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
